[rtl/ohs_pkg.sv]
// shared types and constants for the open addressing hash set
// no dependencies; imported by every module of the block

package ohs_pkg;

	localparam int SLOTS_DEF    = 1024;
	localparam int KEY_BITS_DEF = 32;
	localparam int HASH_W       = 32;
	localparam int KEY_W        = 32;
	localparam int OP_W         = 2;
	localparam int SLOT_W       = 10;
	localparam int LOAD_W       = 11;
	localparam int MAXL_W       = 10;
	localparam int DIV_BITS     = 4;

	localparam logic [MAXL_W-1:0] MAX_LOAD_RST = 10'd768;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_USED  = 2'd1,
		TAG_DEAD  = 2'd2
	} tag_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_FINISH
	} st_t;

	// one result word as shown on the output ports
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic              status;
	} res_t;

endpackage

[rtl/ohs_hash_div.sv]
// start slot and odd probe step from the 32-bit hash
// uses ohs_pkg; bit slicing for power-of-two tables, radix-16 long division otherwise

module ohs_hash_div
	import ohs_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IW    = $clog2(SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] hv,
	output logic              done,
	output logic [IW-1:0]     pos,
	output logic [IW-1:0]     step
);

	localparam bit POW2 = ((64'd1 << IW) == 64'(SLOTS));

	generate
		if (POW2) begin : g_pow2
			logic [HASH_W-1:0] hq;
			logic [IW-1:0]     pos_q;
			logic [IW-1:0]     step_q;
			logic              done_q;

			assign hq = hv >> IW;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					pos_q  <= hv[IW-1:0];
					step_q <= hq[IW-1:0] | IW'(1);
				end
			end

			assign done = done_q;
			assign pos  = pos_q;
			assign step = step_q;
		end else begin : g_div
			localparam int ITER = HASH_W / DIV_BITS;
			localparam int CNTW = $clog2(ITER);
			localparam logic [IW:0] SMOD = (IW+1)'(SLOTS);

			logic [IW-1:0]     rem_q;
			logic [IW-1:0]     rq_q;
			logic [HASH_W-1:0] sh_q;
			logic [CNTW-1:0]   cnt_q;
			logic              run_q;
			logic              done_q;
			logic [IW-1:0]     rem_d;
			logic [IW-1:0]     rq_d;
			logic [HASH_W-1:0] sh_d;
			logic [IW:0]       s_odd;

			// rem tracks hv mod SLOTS, rq tracks the quotient mod SLOTS
			always_comb begin
				logic [IW:0] t;
				logic [IW:0] t2;
				logic        qb;
				rem_d = rem_q;
				rq_d  = rq_q;
				sh_d  = sh_q;
				for (int i = 0; i < DIV_BITS; i++) begin
					t    = {rem_d, sh_d[HASH_W-1]};
					sh_d = sh_d << 1;
					qb   = (t >= SMOD);
					if (qb) t = t - SMOD;
					rem_d = t[IW-1:0];
					t2    = {rq_d, qb};
					if (t2 >= SMOD) t2 = t2 - SMOD;
					rq_d  = t2[IW-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						run_q <= 1'b1;
						cnt_q <= '0;
					end else if (run_q) begin
						cnt_q <= cnt_q + CNTW'(1);
						if (cnt_q == CNTW'(ITER - 1)) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= '0;
					rq_q  <= '0;
					sh_q  <= hv;
				end else if (run_q) begin
					rem_q <= rem_d;
					rq_q  <= rq_d;
					sh_q  <= sh_d;
				end
			end

			// odd step that lands on SLOTS falls back to one
			assign s_odd = {1'b0, rq_q | IW'(1)};
			assign done  = done_q;
			assign pos   = rem_q;
			assign step  = (s_odd >= SMOD) ? IW'(1) : s_odd[IW-1:0];
		end
	endgenerate

endmodule

[rtl/ohs_slot_mem.sv]
// slot store: tag and key per slot, one write and one registered read port
// uses ohs_pkg for the default depth and key width; plain synchronous memory

module ohs_slot_mem
	import ohs_pkg::*;
#(
	parameter int DEPTH = SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = KEY_BITS_DEF + 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/ohs_probe_ctrl.sv]
// probe sequencer: clearing pass, probe walk over the slot store, update and result
// uses ohs_pkg; drives ohs_hash_div and ohs_slot_mem from the top level

module ohs_probe_ctrl
	import ohs_pkg::*;
#(
	parameter int SLOTS    = SLOTS_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int IW       = $clog2(SLOTS),
	parameter int DW       = KEY_BITS + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   op,
	input  logic [KEY_W-1:0]  key,
	input  logic [MAXL_W-1:0] max_load,
	output logic              busy,
	output logic              done,
	output res_t              res,
	output logic              div_start,
	input  logic              div_done,
	input  logic [IW-1:0]     div_pos,
	input  logic [IW-1:0]     div_step,
	output logic              mem_we,
	output logic [IW-1:0]     mem_waddr,
	output logic [DW-1:0]     mem_wdata,
	output logic [IW-1:0]     mem_raddr,
	input  logic [DW-1:0]     mem_rdata
);

	localparam int CW = $clog2(SLOTS + 1);

	st_t                st_q, st_d;
	logic [OP_W-1:0]    op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      step_q;
	logic [CW-1:0]      n_q;
	logic [IW-1:0]      dead_pos_q;
	logic               have_dead_q;
	logic               hit_q;
	logic               have_empty_q;
	logic [LOAD_W-1:0]  load_q;
	logic [IW-1:0]      clr_q;
	logic               done_q;
	res_t               res_q, res_d;

	logic [2*KEY_W-1:0] key_wide;
	logic [1:0]         tag_rd;
	logic               is_empty, is_hit, is_dead, last, stop;
	logic [IW:0]        sum;
	logic [IW-1:0]      nxt_pos;
	logic               load_inc;
	logic [1:0]         wtag;
	logic [HASH_W-1:0]  slot_w;

	assign key_wide = {{KEY_W{1'b0}}, key};
	assign tag_rd   = mem_rdata[DW-1:KEY_BITS];
	assign is_empty = (tag_rd == TAG_EMPTY);
	assign is_dead  = (tag_rd == TAG_DEAD);
	assign is_hit   = (tag_rd == TAG_USED) && (mem_rdata[KEY_BITS-1:0] == key_q);
	assign last     = (n_q == CW'(SLOTS));
	assign stop     = is_empty || is_hit || last;

	assign sum     = {1'b0, pos_q} + {1'b0, step_q};
	assign nxt_pos = (sum >= (IW+1)'(SLOTS)) ? IW'(sum - (IW+1)'(SLOTS)) : sum[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		wtag      = TAG_EMPTY;
		mem_raddr = pos_q;
		load_inc  = 1'b0;
		res_d     = '0;
		slot_w    = '0;
		unique case (st_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == IW'(SLOTS - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					div_start = 1'b1;
					st_d      = ST_HASH;
				end
			end
			ST_HASH: begin
				mem_raddr = div_pos;
				if (div_done) st_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (stop) begin
					st_d = ST_FINISH;
				end else begin
					mem_raddr = nxt_pos;
				end
			end
			ST_FINISH: begin
				st_d = ST_IDLE;
				if (hit_q) begin
					res_d.found = 1'b1;
					slot_w      = HASH_W'(pos_q);
					if (op_q == OP_DELETE) begin
						mem_we = 1'b1;
						wtag   = TAG_DEAD;
					end
				end else if (op_q == OP_INSERT) begin
					if (have_dead_q) begin
						mem_we    = 1'b1;
						mem_waddr = dead_pos_q;
						wtag      = TAG_USED;
						slot_w    = HASH_W'(dead_pos_q);
					end else if (have_empty_q && (load_q < {1'b0, max_load})) begin
						mem_we   = 1'b1;
						wtag     = TAG_USED;
						load_inc = 1'b1;
						slot_w   = HASH_W'(pos_q);
					end else begin
						res_d.status = 1'b1;
					end
				end
				res_d.slot = slot_w[SLOT_W-1:0];
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// clearing pass writes empty tags; the key part there is don't care
	assign mem_wdata = {wtag, key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			load_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == ST_FINISH);
			if (st_q == ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (load_inc) load_q <= load_q + LOAD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FINISH) res_q <= res_d;
		if ((st_q == ST_IDLE) && start) begin
			op_q  <= op;
			key_q <= key_wide[KEY_BITS-1:0];
		end
		if ((st_q == ST_HASH) && div_done) begin
			pos_q        <= div_pos;
			step_q       <= div_step;
			n_q          <= CW'(1);
			have_dead_q  <= 1'b0;
			hit_q        <= 1'b0;
			have_empty_q <= 1'b0;
		end
		if (st_q == ST_PROBE) begin
			hit_q        <= is_hit;
			have_empty_q <= is_empty;
			if (is_dead && !have_dead_q) begin
				have_dead_q <= 1'b1;
				dead_pos_q  <= pos_q;
			end
			if (!stop) begin
				pos_q <= nxt_pos;
				n_q   <= n_q + CW'(1);
			end
		end
	end

	assign busy = (st_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/open_addressing_hash_set.sv]
// top level of the open addressing hash set (double hashing, tombstones)
// uses ohs_pkg, ohs_hash_div, ohs_slot_mem and ohs_probe_ctrl
//
// usage
//  - request: drive op, key and hash_value with start; the word is taken at a
//    rising edge with start high and busy low, and busy rises the cycle after
//  - result: one word per request on found, slot and status, shown for exactly
//    one cycle with done high; nothing can hold it off, so capture it then
//  - max_load: write with wr_en and wr_data while no request is in flight
// operation
//  - a power-of-two table slices the hash into start slot and step, then
//    walks the probe chain (one slot store read per cycle), then updates
//    the store if the request calls for it; done shows in the cycle after
//    that, when a new request can already be taken
//  - other table sizes take the hash apart by long division, 4 bits a cycle,
//    before the probe walk starts
// reset
//  - all slot tags are cleared by a pass over every slot with busy high;
//    the load count returns to zero and max_load to 768

module open_addressing_hash_set
	import ohs_pkg::*;
#(
	parameter int SLOTS    = SLOTS_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [KEY_W-1:0]  key,
	input  logic [HASH_W-1:0] hash_value,
	input  logic              wr_en,
	input  logic [MAXL_W-1:0] wr_data,
	output logic              done,
	output logic              found,
	output logic [SLOT_W-1:0] slot,
	output logic              status
);

	// slot index width and slot store word: tag on top, key below
	localparam int IW = $clog2(SLOTS);
	localparam int DW = KEY_BITS + 2;

	logic [MAXL_W-1:0] max_load_q;

	logic          div_start;
	logic          div_done;
	logic [IW-1:0] div_pos;
	logic [IW-1:0] div_step;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	res_t res;

	// load limit register, written straight from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_load_q <= MAX_LOAD_RST;
		end else if (wr_en) begin
			max_load_q <= wr_data;
		end
	end

	// start slot and step from the hash word
	ohs_hash_div #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.hv     (hash_value),
		.done   (div_done),
		.pos    (div_pos),
		.step   (div_step)
	);

	// tag and key per slot, registered read port
	ohs_slot_mem #(
		.DEPTH (SLOTS),
		.AW    (IW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// probe walk reads one slot per cycle; the single write at the end of a
	// request lands before the next request's first read, so no forwarding
	ohs_probe_ctrl #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS),
		.IW       (IW),
		.DW       (DW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.key       (key),
		.max_load  (max_load_q),
		.busy      (busy),
		.done      (done),
		.res       (res),
		.div_start (div_start),
		.div_done  (div_done),
		.div_pos   (div_pos),
		.div_step  (div_step),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// result word fields
	assign found  = res.found;
	assign slot   = res.slot;
	assign status = res.status;

endmodule

[rtl/ohs_check.sv]
// port-level checks for the open addressing hash set
// uses ohs_pkg; bound to open_addressing_hash_set below

module ohs_check
	import ohs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              found,
	input logic [SLOT_W-1:0] slot,
	input logic              status
);

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// the block is free again when a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result shown");

	// a refused insert reports no key and no slot
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !found && (slot == 10'd0))
		else $error("full status with found or slot set");

	// no result appears without a request in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result without request");

endmodule

bind open_addressing_hash_set ohs_check u_ohs_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.found  (found),
	.slot   (slot),
	.status (status)
);

[sim/tb_open_addressing_hash_set.sv]
// testbench for open_addressing_hash_set: queued request words, a clocked driver
// and result monitor, and a behavioral hash table that predicts each answer
// depends on ohs_pkg and the open_addressing_hash_set rtl

module tb_open_addressing_hash_set;
	import ohs_pkg::*;

	localparam int TABLE_SLOTS = SLOTS_DEF;
	localparam int POOL_SIZE   = 64;
	localparam int CYCLE_LIMIT = 5000000;

	// lookup codes not named in the package; the second one is the spare code
	localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP_ALT = 2'd3;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
	} req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [OP_W-1:0]   op = '0;
	logic [KEY_W-1:0]  key = '0;
	logic [HASH_W-1:0] hash_value = '0;
	logic              wr_en = 1'b0;
	logic [MAXL_W-1:0] wr_data = '0;
	logic              done;
	logic              found;
	logic [SLOT_W-1:0] slot;
	logic              status;

	// behavioral copy of the table
	tag_t              slot_state [TABLE_SLOTS];
	logic [KEY_W-1:0]  slot_keys [TABLE_SLOTS];
	int unsigned       load_cnt;
	logic [MAXL_W-1:0] load_limit;

	req_t              waiting_words [$];
	res_t              pending_answers [$];
	req_t              cur_req;
	res_t              want_w;
	int                idle_pct = 0;
	int                errors = 0;
	int                results_seen = 0;
	int                cycle_cnt = 0;

	logic [KEY_W-1:0]  pool_key [POOL_SIZE];
	logic [HASH_W-1:0] pool_hash [POOL_SIZE];

	open_addressing_hash_set u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.key        (key),
		.hash_value (hash_value),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.done       (done),
		.found      (found),
		.slot       (slot),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// probe the table for one request, apply its effect and return the answer
	function automatic res_t apply_request(input req_t w);
		logic [SLOT_W-1:0] pos, step, hit_pos, empty_pos, dead_pos;
		bit                hit, have_empty, have_dead, stop;
		int                n;
		res_t              r;
		pos = w.hash[SLOT_W-1:0];
		step = w.hash[2*SLOT_W-1:SLOT_W];
		step[0] = 1'b1;
		hit = 1'b0;
		have_empty = 1'b0;
		have_dead = 1'b0;
		stop = 1'b0;
		hit_pos = '0;
		empty_pos = '0;
		dead_pos = '0;
		r = '0;
		// walk the chain; tombstones are remembered but passed over
		for (n = 0; n < TABLE_SLOTS && !stop; n++) begin
			if (slot_state[pos] == TAG_EMPTY) begin
				have_empty = 1'b1;
				empty_pos = pos;
				stop = 1'b1;
			end else if (slot_state[pos] == TAG_DEAD) begin
				if (!have_dead) begin
					have_dead = 1'b1;
					dead_pos = pos;
				end
			end else if (slot_keys[pos] == w.key) begin
				hit = 1'b1;
				hit_pos = pos;
				stop = 1'b1;
			end
			if (!stop)
				pos = pos + step;
		end
		if (hit) begin
			r.found = 1'b1;
			r.slot = hit_pos;
			if (w.op == OP_DELETE)
				slot_state[hit_pos] = TAG_DEAD;
		end else if (w.op == OP_INSERT) begin
			if (have_dead) begin
				// a new key takes the first tombstone, load unchanged
				slot_state[dead_pos] = TAG_USED;
				slot_keys[dead_pos] = w.key;
				r.slot = dead_pos;
			end else if (have_empty && load_cnt < load_limit) begin
				slot_state[empty_pos] = TAG_USED;
				slot_keys[empty_pos] = w.key;
				load_cnt++;
				r.slot = empty_pos;
			end else begin
				r.status = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch on result word %0d, %s: wanted %0h, got %0h",
			results_seen, what, want, got);
		errors++;
	endtask

	task automatic push_word(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
		input logic [HASH_W-1:0] h);
		req_t w;
		w.op = o;
		w.key = k;
		w.hash = h;
		waiting_words.push_back(w);
	endtask

	// mostly keys from the pool with their own hash, the rest noise
	task automatic push_random_word();
		int              pick, r;
		logic [OP_W-1:0] o;
		pick = $urandom_range(0, POOL_SIZE - 1);
		r = $urandom_range(0, 99);
		if (r < 40)
			o = OP_INSERT;
		else if (r < 65)
			o = OP_LOOKUP;
		else if (r < 90)
			o = OP_DELETE;
		else
			o = OP_LOOKUP_ALT;
		r = $urandom_range(0, 99);
		if (r < 85)
			push_word(o, pool_key[pick], pool_hash[pick]);
		else if (r < 93)
			push_word(o, $urandom, $urandom);
		else
			push_word(o, pool_key[pick], $urandom);
	endtask

	// block idle: nothing queued, nothing presented, nothing outstanding;
	// sampled at the falling edge so the driver's updates have settled
	task automatic wait_quiet();
		@(negedge clk);
		while (waiting_words.size() != 0 || start || busy || pending_answers.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_load_limit(input logic [MAXL_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		load_limit = v;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// driver: present the next queued word once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pending_answers.push_back(apply_request(cur_req));
			if (!start || !busy) begin
				if (waiting_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_req = waiting_words.pop_front();
					start <= 1'b1;
					op <= cur_req.op;
					key <= cur_req.key;
					hash_value <= cur_req.hash;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done strobe carries one result word
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("word with no request outstanding", '0,
					32'({found, slot, status}));
			end else begin
				want_w = pending_answers.pop_front();
				if (found !== want_w.found)
					report_mismatch("found", 32'(want_w.found), 32'(found));
				if (slot !== want_w.slot)
					report_mismatch("slot", 32'(want_w.slot), 32'(slot));
				if (status !== want_w.status)
					report_mismatch("status", 32'(want_w.status), 32'(status));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			slot_state[i] = TAG_EMPTY;
			slot_keys[i] = '0;
		end
		load_cnt = 0;
		load_limit = MAX_LOAD_RST;

		// key pool; about half the hashes share four home slots so chains form
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
			pool_hash[i] = $urandom;
			if ($urandom_range(0, 1))
				pool_hash[i][SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3) * 341);
		end
		pool_key[0] = '0;
		pool_key[1] = '1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tiny load limit so the full refusal is reached early
		idle_pct = 29;
		set_load_limit(10'd3);
		push_word(OP_LOOKUP, 32'h1234_5678, 32'h0000_0C05);     // lookup miss
		push_word(OP_DELETE, 32'h1234_5678, 32'h0000_0C05);     // delete miss
		push_word(OP_INSERT, 32'h1234_5678, 32'h0000_0C05);     // takes slot 5
		push_word(OP_INSERT, 32'h1234_5678, 32'h0000_0C05);     // already present
		push_word(OP_INSERT, 32'h0000_0000, 32'h0000_0C05);     // zero key, collides
		push_word(OP_LOOKUP_ALT, 32'h0000_0000, 32'h0000_0C05); // spare code looks up
		push_word(OP_DELETE, 32'h1234_5678, 32'h0000_0C05);     // leaves a tombstone
		push_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0C05);     // probes past it
		push_word(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0C05);     // all-ones key reuses it
		push_word(OP_INSERT, 32'h89AB_CDEF, 32'hFFFF_FFFF);     // top slot, widest step
		push_word(OP_INSERT, 32'h0BAD_F00D, 32'h0000_0000);     // over the load limit
		push_word(OP_DELETE, 32'h89AB_CDEF, 32'hFFFF_FFFF);
		push_word(OP_INSERT, 32'h0BAD_F00D, 32'hFFFF_FFFF);     // refilled from tombstone
		push_word(OP_LOOKUP, 32'h89AB_CDEF, 32'hFFFF_FFFF);     // miss after a pass
		push_word(OP_LOOKUP_ALT, 32'h5A5A_A5A5, 32'h0000_0000);
		push_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0C05);
		push_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0C05);     // second delete misses
		push_word(OP_INSERT, 32'h7FFF_FFFE, 32'h0000_0C05);     // reuse slot 5 again
		push_word(OP_INSERT, 32'h8000_0001, 32'hA5A5_5A5A);     // full, no tombstone
		push_word(OP_LOOKUP, 32'h0BAD_F00D, 32'hFFFF_FFFF);

		set_load_limit(10'd1023);
		repeat (400) push_random_word();

		// lowest limit: only tombstone reuse lets a new key in
		idle_pct = 78;
		set_load_limit(10'd1);
		repeat (250) push_random_word();

		idle_pct = 0;
		set_load_limit(MAXL_W'($urandom_range(300, 700)));
		repeat (500) push_random_word();

		wait_quiet();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
